// ===== rtl/bcmf_pkg.sv =====
// ----------------------------------------------------------------------------
// bcmf_pkg - shared types and constants for the BUFR/CREX message framer
// Signature and end-marker tables, status codes and the result descriptor
// passed from the step engine to the result emitter.
// ----------------------------------------------------------------------------
package bcmf_pkg;

    // Width of the stream position counter (wraps at this width)
    localparam int POSITION_BITS = 32;
    // Width of the reported message offset
    localparam int OFFSET_BITS   = 32;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_MSG    = 2'd1;
    localparam logic [1:0] ST_SHORT_LEN = 2'd2;
    localparam logic [1:0] ST_TRUNC     = 2'd3;

    // Input command codes
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_EOS  = 1'b1;

    // Signature lengths
    localparam logic [2:0] SIG_LEN_BUFR = 3'd4;
    localparam logic [2:0] SIG_LEN_CREX = 3'd6;

    // One entry of work handed to the emitter: either a single result,
    // or a signature burst expanded from the mode and offset.
    typedef struct packed {
        logic                   burst;
        logic                   mode;
        logic [7:0]             data;
        logic                   first;
        logic                   last;
        logic [1:0]             status;
        logic [OFFSET_BITS-1:0] offset;
    } bcmf_desc_t;

    // Signature length for a format mode
    function automatic logic [2:0] sig_len(input logic mode);
        return mode ? SIG_LEN_CREX : SIG_LEN_BUFR;
    endfunction

    // Signature byte at a given index for a format mode
    function automatic logic [7:0] sig_char(input logic mode, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        if (mode)
        begin
            unique case (idx)
                3'd0:    ch = "C";
                3'd1:    ch = "R";
                3'd2:    ch = "E";
                3'd3:    ch = "X";
                3'd4:    ch = "+";
                3'd5:    ch = "+";
                default: ch = 8'h00;
            endcase
        end
        else
        begin
            unique case (idx)
                3'd0:    ch = "B";
                3'd1:    ch = "U";
                3'd2:    ch = "F";
                3'd3:    ch = "R";
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

    // CREX end marker: "++", CR, LF, "7777"
    function automatic logic [7:0] end_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = "+";
            3'd1:    ch = "+";
            3'd2:    ch = 8'h0D;
            3'd3:    ch = 8'h0A;
            default: ch = "7";
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/bcmf_if.sv =====
// ----------------------------------------------------------------------------
// bcmf_in_if / bcmf_out_if - valid/ready channels of the message framer
// Input carries stream bytes and commands, output carries framed results.
// ----------------------------------------------------------------------------
interface bcmf_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] in_byte;

    modport source (output valid, output command, output in_byte, input ready);
    modport sink   (input valid, input command, input in_byte, output ready);
endinterface

interface bcmf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        first_of_message;
    logic        last_of_message;
    logic [1:0]  status;
    logic [31:0] message_offset;

    modport source (output valid, output out_byte, output first_of_message,
                    output last_of_message, output status, output message_offset,
                    input ready);
    modport sink   (input valid, input out_byte, input first_of_message,
                    input last_of_message, input status, input message_offset,
                    output ready);
endinterface

// ===== rtl/bufr_crex_message_framer_core.sv =====
// ----------------------------------------------------------------------------
// bufr_crex_message_framer_core - BUFR/CREX message delimiter
// Hunts a byte stream for message signatures and passes framed messages on.
// ----------------------------------------------------------------------------
// Usage:
//   stream : valid/ready input, one transaction per stream byte (command 0)
//            or an end-of-stream marker (command 1, byte ignored).
//   framed : valid/ready output, one transaction per result: byte, first and
//            last flags, status and the stream offset of the message start.
//   format_mode_we/format_mode_wdata : selects BUFR (0) or CREX (1) framing;
//            write only while the block is idle.
// A result passes the descriptor register, then the output register. One input
// transaction is taken per cycle while the descriptor register can take it; a
// completed signature produces a burst of 4 (BUFR) or 6 (CREX) results from
// the emitter, and input is held off while the burst drains, once per message.
// Reset clears the framing state, the stream position and the format to BUFR
// and empties the output stage. When the receiver stalls, the output register
// and the descriptor register hold one result each, then input ready drops.
// ----------------------------------------------------------------------------
module bufr_crex_message_framer_core
    import bcmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        format_mode_we,
    input  logic        format_mode_wdata,
    bcmf_in_if.sink     stream,
    bcmf_out_if.source  framed
);

    logic       format_mode_reg;
    logic       desc_valid;
    logic       desc_take;
    bcmf_desc_t desc;

    // Format register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            format_mode_reg <= 1'b0;
        else if (format_mode_we)
            format_mode_reg <= format_mode_wdata;
    end

    bcmf_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .format_mode (format_mode_reg),
        .stream      (stream),
        .desc_valid  (desc_valid),
        .desc        (desc),
        .desc_take   (desc_take)
    );

    bcmf_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc_valid),
        .desc       (desc),
        .desc_take  (desc_take),
        .framed     (framed)
    );

endmodule

// ===== rtl/bcmf_engine.sv =====
// ----------------------------------------------------------------------------
// bcmf_engine - per-byte framing step
// Holds the framing state, processes one accepted transaction per cycle and
// registers the resulting descriptor for the emitter.
// ----------------------------------------------------------------------------
module bcmf_engine
    import bcmf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              format_mode,
    bcmf_in_if.sink           stream,
    output logic              desc_valid,
    output bcmf_desc_t        desc,
    input  logic              desc_take
);

    // Phase codes
    localparam logic [1:0] PH_HUNT      = 2'd0;
    localparam logic [1:0] PH_BUFR_HEAD = 2'd1;
    localparam logic [1:0] PH_BUFR_BODY = 2'd2;
    localparam logic [1:0] PH_CREX_BODY = 2'd3;

    localparam logic [23:0] MIN_LEN  = 24'd12;
    localparam logic [23:0] HEAD_END = 24'd8;
    localparam logic [23:0] LEN_MAX  = 24'hFFFFFF;
    localparam logic [7:0]  CH_CR    = 8'h0D;
    localparam logic [7:0]  CH_LF    = 8'h0A;
    localparam logic [7:0]  CH_SEVEN = "7";

    logic [1:0]               phase_reg,  phase_next;
    logic [2:0]               sig_reg,    sig_next;
    logic [2:0]               end_reg,    end_next;
    logic [23:0]              count_reg,  count_next;
    logic [23:0]              dlen_reg,   dlen_next;
    logic [POSITION_BITS-1:0] pos_reg,    pos_next;
    logic [POSITION_BITS-1:0] start_reg,  start_next;
    logic                     desc_valid_reg, desc_valid_next;
    bcmf_desc_t               desc_reg,   desc_next;

    logic                     accept;
    logic                     emit;
    bcmf_desc_t               res;
    logic [7:0]               c;
    logic [2:0]               len;
    logic [2:0]               sm;
    logic [3:0]               g;
    logic [7:0]               t;
    logic                     crlf;
    logic [23:0]              cnt_inc;
    logic [23:0]              dl;

    assign stream.ready = !desc_valid_reg || desc_take;
    assign accept       = stream.valid && stream.ready;
    assign c            = stream.in_byte;
    assign desc_valid   = desc_valid_reg;
    assign desc         = desc_reg;

    // Framing step for one transaction
    always_comb
    begin
        phase_next = phase_reg;
        sig_next   = sig_reg;
        end_next   = end_reg;
        count_next = count_reg;
        dlen_next  = dlen_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        emit       = 1'b0;
        len        = sig_len(format_mode);
        sm         = 3'd0;
        g          = 4'd0;
        t          = end_char(end_reg);
        crlf       = (c == CH_CR) || (c == CH_LF);
        cnt_inc    = count_reg + 24'd1;
        dl         = dlen_reg;

        res.burst  = 1'b0;
        res.mode   = format_mode;
        res.data   = c;
        res.first  = 1'b0;
        res.last   = 1'b0;
        res.status = ST_OK;
        res.offset = OFFSET_BITS'(start_reg);

        if (stream.command == CMD_EOS)
        begin
            // End of stream: status result, back to hunting, position restarts
            emit     = 1'b1;
            res.data = 8'h00;
            res.last = 1'b1;
            if (phase_reg == PH_HUNT)
            begin
                res.status = ST_NO_MSG;
                res.offset = '0;
            end
            else
            begin
                res.status = ST_TRUNC;
            end
            phase_next = PH_HUNT;
            sig_next   = 3'd0;
            end_next   = 3'd0;
            count_next = 24'd0;
            dlen_next  = 24'd0;
            pos_next   = '0;
        end
        else
        begin
            pos_next = pos_reg + POSITION_BITS'(1);
            unique case (phase_reg)
                PH_HUNT:
                begin
                    // Naive signature match
                    if ((sig_reg < len) && (c == sig_char(format_mode, sig_reg)))
                        sm = sig_reg + 3'd1;
                    else
                        sm = 3'd0;
                    sig_next = sm;
                    if (sm == len)
                    begin
                        emit       = 1'b1;
                        start_next = pos_reg - POSITION_BITS'(len - 3'd1);
                        res.burst  = 1'b1;
                        res.first  = 1'b1;
                        res.offset = OFFSET_BITS'(start_next);
                        sig_next   = 3'd0;
                        end_next   = 3'd0;
                        count_next = 24'(len);
                        dlen_next  = 24'd0;
                        phase_next = format_mode ? PH_CREX_BODY : PH_BUFR_HEAD;
                    end
                end
                PH_BUFR_HEAD:
                begin
                    // Big-endian 24-bit length in bytes 4..6
                    unique case (count_reg[1:0])
                        2'd0:    dl = {c, 16'h0000};
                        2'd1:    dl = dlen_reg | {8'h00, c, 8'h00};
                        2'd2:    dl = dlen_reg | {16'h0000, c};
                        default: dl = dlen_reg;
                    endcase
                    dlen_next  = dl;
                    count_next = cnt_inc;
                    emit       = 1'b1;
                    if (cnt_inc >= HEAD_END)
                    begin
                        if (dl < MIN_LEN)
                        begin
                            res.last   = 1'b1;
                            res.status = ST_SHORT_LEN;
                            phase_next = PH_HUNT;
                            count_next = 24'd0;
                            dlen_next  = 24'd0;
                        end
                        else
                        begin
                            phase_next = PH_BUFR_BODY;
                        end
                    end
                end
                PH_BUFR_BODY:
                begin
                    emit       = 1'b1;
                    count_next = cnt_inc;
                    if (cnt_inc >= dlen_reg)
                    begin
                        res.last   = 1'b1;
                        phase_next = PH_HUNT;
                        count_next = 24'd0;
                        dlen_next  = 24'd0;
                    end
                end
                default:
                begin
                    // CREX end marker with flexible CR/LF run
                    priority if ((t == CH_CR) && crlf)
                        g = {1'b0, end_reg} + 4'd1;
                    else if ((t == CH_LF) && crlf)
                        g = {1'b0, end_reg};
                    else if ((t == CH_LF) && (c == CH_SEVEN))
                        g = {1'b0, end_reg} + 4'd2;
                    else if (c == t)
                        g = {1'b0, end_reg} + 4'd1;
                    else
                        g = 4'd0;
                    end_next = g[2:0];
                    if (count_reg != LEN_MAX)
                        count_next = cnt_inc;
                    emit = 1'b1;
                    if (g[3])
                    begin
                        res.last   = 1'b1;
                        phase_next = PH_HUNT;
                        end_next   = 3'd0;
                        count_next = 24'd0;
                        dlen_next  = 24'd0;
                    end
                end
            endcase
        end

        // Descriptor register handover
        desc_next = desc_reg;
        if (accept && emit)
        begin
            desc_valid_next = 1'b1;
            desc_next       = res;
        end
        else if (desc_take)
        begin
            desc_valid_next = 1'b0;
        end
        else
        begin
            desc_valid_next = desc_valid_reg;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            sig_reg        <= 3'd0;
            end_reg        <= 3'd0;
            count_reg      <= 24'd0;
            dlen_reg       <= 24'd0;
            pos_reg        <= '0;
            start_reg      <= '0;
            desc_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                sig_reg   <= sig_next;
                end_reg   <= end_next;
                count_reg <= count_next;
                dlen_reg  <= dlen_next;
                pos_reg   <= pos_next;
                start_reg <= start_next;
            end
            desc_valid_reg <= desc_valid_next;
        end
    end

    // Descriptor payload
    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

endmodule

// ===== rtl/bcmf_emitter.sv =====
// ----------------------------------------------------------------------------
// bcmf_emitter - result output stage
// Expands signature bursts into one result per cycle while the receiver
// takes them, and holds the output register towards the receiver.
// ----------------------------------------------------------------------------
module bcmf_emitter
    import bcmf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              desc_valid,
    input  bcmf_desc_t        desc,
    output logic              desc_take,
    bcmf_out_if.source        framed
);

    logic                   out_valid_reg,  out_valid_next;
    logic [7:0]             data_reg,       data_next;
    logic                   first_reg,      first_next;
    logic                   last_reg,       last_next;
    logic [1:0]             status_reg,     status_next;
    logic [OFFSET_BITS-1:0] offset_reg,     offset_next;
    logic [2:0]             left_reg,       left_next;
    logic [2:0]             idx_reg,        idx_next;
    logic                   mode_reg,       mode_next;
    logic [OFFSET_BITS-1:0] boff_reg,       boff_next;
    logic                   advance;

    assign advance   = !out_valid_reg || framed.ready;
    assign desc_take = advance && (left_reg == 3'd0) && desc_valid;

    assign framed.valid            = out_valid_reg;
    assign framed.out_byte         = data_reg;
    assign framed.first_of_message = first_reg;
    assign framed.last_of_message  = last_reg;
    assign framed.status           = status_reg;
    assign framed.message_offset   = offset_reg;

    // Next output selection: burst continuation first, then a new descriptor
    always_comb
    begin
        out_valid_next = out_valid_reg;
        data_next      = data_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        offset_next    = offset_reg;
        left_next      = left_reg;
        idx_next       = idx_reg;
        mode_next      = mode_reg;
        boff_next      = boff_reg;
        if (advance)
        begin
            priority if (left_reg != 3'd0)
            begin
                out_valid_next = 1'b1;
                data_next      = sig_char(mode_reg, idx_reg);
                first_next     = 1'b0;
                last_next      = 1'b0;
                status_next    = ST_OK;
                offset_next    = boff_reg;
                idx_next       = idx_reg + 3'd1;
                left_next      = left_reg - 3'd1;
            end
            else if (desc_valid)
            begin
                out_valid_next = 1'b1;
                first_next     = desc.first;
                last_next      = desc.last;
                status_next    = desc.status;
                offset_next    = desc.offset;
                if (desc.burst)
                begin
                    data_next = sig_char(desc.mode, 3'd0);
                    idx_next  = 3'd1;
                    left_next = sig_len(desc.mode) - 3'd1;
                    mode_next = desc.mode;
                    boff_next = desc.offset;
                end
                else
                begin
                    data_next = desc.data;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            left_reg      <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            left_reg      <= left_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        first_reg  <= first_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        offset_reg <= offset_next;
        idx_reg    <= idx_next;
        mode_reg   <= mode_next;
        boff_reg   <= boff_next;
    end

`ifndef NO_ASSERTIONS
    // No new descriptor is taken while a burst is still being expanded
    a_no_take_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (left_reg != 3'd0) |-> !desc_take)
        else $error("descriptor taken during signature burst");

    // Burst remainder never exceeds the longest signature
    a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= (SIG_LEN_CREX - 3'd1))
        else $error("burst counter out of range");

    // A message start is a plain, non-final data result
    a_first_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && first_reg) |-> ((status_reg == ST_OK) && !last_reg))
        else $error("first result carries an end or status flag");

    // A burst continues into the next output once the current one is taken
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (left_reg != 3'd0 && advance) |=> (out_valid_reg && !first_reg))
        else $error("signature burst interrupted");
`endif

endmodule
